// ===== hw/rtl/qapm_pkg.sv =====
// Shared constants, types and state codes of the attitude PID and motor mixer.
`default_nettype none
package qapm_pkg;

    localparam int WINDOW     = 5;
    localparam int ANGLE_W    = 16;
    localparam int DUTY_W     = 16;
    localparam int GAIN_P_W   = 10;
    localparam int GAIN_I_W   = 10;
    localparam int GAIN_D_W   = 12;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = ANGLE_W + $clog2(WINDOW);
    localparam int ISUM_W  = LIMIT_W + 1;
    localparam int MUL_A_W = GAIN_D_W;
    localparam int MUL_B_W = ANGLE_W + 1;
    localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
    localparam int ACC_W   = 32;
    localparam int TERM_W  = ACC_W - 8;
    localparam int MIX_W   = TERM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_BASE_DUTY      = 3'd3,
        CFG_MAX_DUTY       = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     clamp;
        logic     mul_en;
        t_mul_sel mul_sel;
    } t_lane_ctrl;

    typedef struct packed {
        logic mix_en;
        logic out_load;
    } t_mix_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_MIX,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/qapm_axis_lane.sv =====
// One axis lane: error window, clamped window sum and the PID term.
`default_nettype none
module qapm_axis_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire qapm_pkg::t_lane_ctrl                  i_ctrl,
    input  wire logic signed [qapm_pkg::ANGLE_W-1:0]   i_sample,
    input  wire logic [qapm_pkg::GAIN_P_W-1:0]         i_gain_p,
    input  wire logic [qapm_pkg::GAIN_I_W-1:0]         i_gain_i,
    input  wire logic [qapm_pkg::GAIN_D_W-1:0]         i_gain_d,
    input  wire logic [qapm_pkg::LIMIT_W-1:0]          i_integral_limit,
    output logic signed [qapm_pkg::TERM_W-1:0]         o_term
);
    import qapm_pkg::*;

    logic signed [ANGLE_W-1:0] r_hist [WINDOW];
    logic [SLOT_W-1:0]         r_slot;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [ANGLE_W-1:0] r_prev;

    logic signed [ANGLE_W-1:0] r_e;
    logic signed [MUL_B_W-1:0] r_diff;
    logic signed [ISUM_W-1:0]  r_isum;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [ANGLE_W-1:0] old_sample;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [ISUM_W-1:0]  n_isum;
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    assign old_sample = r_hist[r_slot];

    // The window sum is kept running: add the new sample, drop the one it overwrites.
    assign n_sum = r_sum - SUM_W'(old_sample) + SUM_W'(i_sample);

    assign lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, i_integral_limit});
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (r_sum > lim_pos) begin
            n_isum = ISUM_W'(lim_pos);
        end else if (r_sum < lim_neg) begin
            n_isum = ISUM_W'(lim_neg);
        end else begin
            n_isum = ISUM_W'(r_sum);
        end
    end

    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_P: begin
                mul_a = MUL_A_W'(i_gain_p);
                mul_b = MUL_B_W'(r_e);
            end
            MUL_I: begin
                mul_a = MUL_A_W'(i_gain_i);
                mul_b = MUL_B_W'(r_isum);
            end
            MUL_D: begin
                mul_a = i_gain_d;
                mul_b = r_diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = $signed({1'b0, mul_a}) * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_hist[k] <= '0;
            end
            r_slot <= '0;
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_ctrl.load) begin
            r_hist[r_slot] <= i_sample;
            r_sum          <= n_sum;
            r_prev         <= i_sample;
            if (r_slot == SLOT_W'(WINDOW - 1)) begin
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_e    <= i_sample;
            r_diff <= MUL_B_W'(i_sample) - MUL_B_W'(r_prev);
        end
        if (i_ctrl.clamp) begin
            r_isum <= n_isum;
        end
        if (i_ctrl.mul_en) begin
            if (i_ctrl.mul_sel == MUL_P) begin
                r_acc <= ACC_W'(prod);
            end else begin
                r_acc <= r_acc + ACC_W'(prod);
            end
        end
    end

    // Dropping the low eight bits of a two's complement value is a floor shift.
    assign o_term = r_acc[ACC_W-1:8];

endmodule
`default_nettype wire

// ===== hw/rtl/qapm_mixer.sv =====
// Merge stage: mixes the two axis terms onto four motors and clamps each duty.
`default_nettype none
module qapm_mixer (
    input  wire logic                                 i_clk,
    input  wire qapm_pkg::t_mix_ctrl                  i_ctrl,
    input  wire logic signed [qapm_pkg::TERM_W-1:0]   i_pitch_term,
    input  wire logic signed [qapm_pkg::TERM_W-1:0]   i_roll_term,
    input  wire logic [qapm_pkg::DUTY_W-1:0]          i_base_duty,
    input  wire logic [qapm_pkg::DUTY_W-1:0]          i_max_duty,
    output logic [qapm_pkg::DUTY_W-1:0]               o_duty [4]
);
    import qapm_pkg::*;

    logic signed [MIX_W-1:0] r_mix [4];
    logic [DUTY_W-1:0]       r_duty [4];

    logic signed [MIX_W-1:0] base_ext;
    logic signed [MIX_W-1:0] tp;
    logic signed [MIX_W-1:0] tr;
    logic signed [MIX_W-1:0] max_ext;
    logic [DUTY_W-1:0]       n_duty [4];

    assign base_ext = $signed({{(MIX_W-DUTY_W){1'b0}}, i_base_duty});
    assign max_ext  = $signed({{(MIX_W-DUTY_W){1'b0}}, i_max_duty});
    assign tp       = MIX_W'(i_pitch_term);
    assign tr       = MIX_W'(i_roll_term);

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            priority if (r_mix[m] < 0) begin
                n_duty[m] = '0;
            end else if (r_mix[m] > max_ext) begin
                n_duty[m] = i_max_duty;
            end else begin
                n_duty[m] = r_mix[m][DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mix_en) begin
            r_mix[0] <= base_ext + tp + tr;
            r_mix[1] <= base_ext + tp - tr;
            r_mix[2] <= base_ext - tp - tr;
            r_mix[3] <= base_ext - tp + tr;
        end
        if (i_ctrl.out_load) begin
            for (int m = 0; m < 4; m++) begin
                r_duty[m] <= n_duty[m];
            end
        end
    end

    assign o_duty = r_duty;

endmodule
`default_nettype wire

// ===== hw/rtl/quadrotor_attitude_pid_mixer.sv =====
// Top level: configuration registers, sequencer, two axis lanes and the motor mixer.
// An accepted word passes the clamp, multiply and mix states before its four duties
// are loaded. No new word is taken until the sequencer returns to idle, as the
// shared multiplier in each lane forms the three gain products one after another.
// A finished word waits in the output register while the next word is taken.
// Synchronous active-low reset restores the gains, duties and integral limit, and clears both error windows.
`default_nettype none
module quadrotor_attitude_pid_mixer (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [qapm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [qapm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  i_pitch_angle,
    input  wire logic signed [qapm_pkg::ANGLE_W-1:0]  i_roll_angle,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [qapm_pkg::DUTY_W-1:0]               o_motor1_duty,
    output logic [qapm_pkg::DUTY_W-1:0]               o_motor2_duty,
    output logic [qapm_pkg::DUTY_W-1:0]               o_motor3_duty,
    output logic [qapm_pkg::DUTY_W-1:0]               o_motor4_duty
);
    import qapm_pkg::*;

    logic [GAIN_P_W-1:0] r_gain_p;
    logic [GAIN_I_W-1:0] r_gain_i;
    logic [GAIN_D_W-1:0] r_gain_d;
    logic [DUTY_W-1:0]   r_base_duty;
    logic [DUTY_W-1:0]   r_max_duty;
    logic [LIMIT_W-1:0]  r_integral_limit;

    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic       in_take;
    logic       out_free;
    t_lane_ctrl lane_ctrl;
    t_mix_ctrl  mix_ctrl;

    logic signed [TERM_W-1:0] pitch_term;
    logic signed [TERM_W-1:0] roll_term;
    logic [DUTY_W-1:0]        duty [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p         <= GAIN_P_W'(16);
            r_gain_i         <= GAIN_I_W'(2);
            r_gain_d         <= GAIN_D_W'(700);
            r_base_duty      <= DUTY_W'(4750);
            r_max_duty       <= DUTY_W'(7000);
            r_integral_limit <= LIMIT_W'(5120);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GAIN_P:         r_gain_p         <= i_cfg_data[GAIN_P_W-1:0];
                CFG_GAIN_I:         r_gain_i         <= i_cfg_data[GAIN_I_W-1:0];
                CFG_GAIN_D:         r_gain_d         <= i_cfg_data[GAIN_D_W-1:0];
                CFG_BASE_DUTY:      r_base_duty      <= i_cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY:       r_max_duty       <= i_cfg_data[DUTY_W-1:0];
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_take) n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_MUL_I;
            ST_MUL_I: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_MIX;
            ST_MIX:   n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl = '{load: 1'b0, clamp: 1'b0, mul_en: 1'b0, mul_sel: MUL_P};
        mix_ctrl  = '{mix_en: 1'b0, out_load: 1'b0};
        unique case (r_state)
            ST_IDLE:  lane_ctrl.load = in_take;
            ST_CLAMP: lane_ctrl.clamp = 1'b1;
            ST_MUL_P: begin
                lane_ctrl.mul_en  = 1'b1;
                lane_ctrl.mul_sel = MUL_P;
            end
            ST_MUL_I: begin
                lane_ctrl.mul_en  = 1'b1;
                lane_ctrl.mul_sel = MUL_I;
            end
            ST_MUL_D: begin
                lane_ctrl.mul_en  = 1'b1;
                lane_ctrl.mul_sel = MUL_D;
            end
            ST_MIX:   mix_ctrl.mix_en = 1'b1;
            ST_OUT:   mix_ctrl.out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mix_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    qapm_axis_lane u_pitch_lane (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (lane_ctrl),
        .i_sample         (i_pitch_angle),
        .i_gain_p         (r_gain_p),
        .i_gain_i         (r_gain_i),
        .i_gain_d         (r_gain_d),
        .i_integral_limit (r_integral_limit),
        .o_term           (pitch_term)
    );

    qapm_axis_lane u_roll_lane (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (lane_ctrl),
        .i_sample         (i_roll_angle),
        .i_gain_p         (r_gain_p),
        .i_gain_i         (r_gain_i),
        .i_gain_d         (r_gain_d),
        .i_integral_limit (r_integral_limit),
        .o_term           (roll_term)
    );

    qapm_mixer u_mixer (
        .i_clk        (i_clk),
        .i_ctrl       (mix_ctrl),
        .i_pitch_term (pitch_term),
        .i_roll_term  (roll_term),
        .i_base_duty  (r_base_duty),
        .i_max_duty   (r_max_duty),
        .o_duty       (duty)
    );

    assign o_out_valid   = r_out_valid;
    assign o_motor1_duty = duty[0];
    assign o_motor2_duty = duty[1];
    assign o_motor3_duty = duty[2];
    assign o_motor4_duty = duty[3];

endmodule
`default_nettype wire
